/* hdl/vvfc_pkg.sv */
// Shared constants, types and helpers for the voxel visible-face cull block.
`default_nettype none
package vvfc_pkg;

   localparam int VVFC_SIDE = 16;
   localparam int VVFC_TALL = 256;

   localparam int POS_XZ_W = 4;
   localparam int POS_Y_W  = 8;
   localparam int MASK_W   = 6;

   // face bit positions in face_mask
   localparam int FACE_BOTTOM = 0;
   localparam int FACE_TOP    = 1;
   localparam int FACE_LEFT   = 2;
   localparam int FACE_RIGHT  = 3;
   localparam int FACE_FRONT  = 4;
   localparam int FACE_BACK   = 5;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // read sequence steps: self row, then four neighbor rows
   localparam logic [2:0] STEP_SELF   = 3'd0;
   localparam logic [2:0] STEP_LEFT   = 3'd1;
   localparam logic [2:0] STEP_RIGHT  = 3'd2;
   localparam logic [2:0] STEP_BOTTOM = 3'd3;
   localparam logic [2:0] STEP_TOP    = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

/* hdl/vvfc_if.sv */
// Valid/ready channel interfaces for request and response beats.
`default_nettype none
interface vvfc_req_if;
   import vvfc_pkg::*;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [POS_XZ_W-1:0] pos_x;
   logic [POS_Y_W-1:0]  pos_y;
   logic [POS_XZ_W-1:0] pos_z;
   logic                solid;

   modport source (output valid, kind, pos_x, pos_y, pos_z, solid, input ready);
   modport sink   (input valid, kind, pos_x, pos_y, pos_z, solid, output ready);
endinterface

interface vvfc_rsp_if;
   import vvfc_pkg::*;
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] face_mask;
   logic              voxel_solid;

   modport source (output valid, face_mask, voxel_solid, input ready);
   modport sink   (input valid, face_mask, voxel_solid, output ready);
endinterface
`default_nettype wire

/* hdl/vvfc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vvfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hdl/voxel_visible_face_cull.sv */
// Voxel visible-face cull: occupancy map in a row RAM, face mask by sequenced row reads.
// Write beat: accept, then read-modify-write of the z row.
// Read beat: accept, then row reads of the own z row, then x-1, x+1, y-1, y+1; the result is registered in DONE.
// A finished result sits in the output register; the next beat is accepted meanwhile.
// After reset a clearing pass zeroes one row per cycle, all CHUNK_SIDE*CHUNK_TALL rows
//   (4096 by default); req ready stays low until it ends.
`default_nettype none
module voxel_visible_face_cull #(
   parameter int CHUNK_SIDE = vvfc_pkg::VVFC_SIDE,
   parameter int CHUNK_TALL = vvfc_pkg::VVFC_TALL
) (
   input wire logic clock,
   input wire logic reset,
   vvfc_req_if.sink   req_bus,
   vvfc_rsp_if.source rsp_bus
);
   import vvfc_pkg::*;

   localparam int ROWS  = CHUNK_SIDE * CHUNK_TALL;
   localparam int AW    = $clog2(ROWS);
   localparam int ROW_W = CHUNK_SIDE;

   function automatic logic [AW-1:0] row_addr(input int x, input int y);
      int a;
      a = y * CHUNK_SIDE + x;
      return AW'(a);
   endfunction

   function automatic logic row_bit(input logic [ROW_W-1:0] row, input int idx);
      logic [ROW_W-1:0] sh;
      sh = row >> idx;
      return sh[0];
   endfunction

   state_type           state_ff, state_in;
   logic [2:0]          step_ff, step_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [POS_XZ_W-1:0] x_ff, x_in, z_ff, z_in;
   logic [POS_Y_W-1:0]  y_ff, y_in;
   logic                solid_ff, solid_in;
   logic                inside_ff, inside_in;
   logic                self_ff, self_in;
   logic [MASK_W-1:0]   vis_ff, vis_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic                vsolid_ff, vsolid_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [ROW_W-1:0] wr_data, rd_data, z_onehot;
   logic             req_fire, load_rsp, bit_z;
   int               xi, yi, zi;

   vvfc_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_fire = req_bus.valid && req_bus.ready;
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            step_in = STEP_SELF;
            if (req_fire) begin
               state_in = (req_bus.kind == KIND_READ) ? ST_READ : ST_WRITE;
            end
         end
         ST_WRITE: state_in = ST_IDLE;
         ST_READ: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_TOP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      xi = int'(x_ff);
      yi = int'(y_ff);
      zi = int'(z_ff);
      bit_z    = row_bit(rd_data, zi);
      z_onehot = ROW_W'(1) << zi;

      req_bus.ready = (state_ff == ST_IDLE);
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      solid_in  = solid_ff;
      inside_in = inside_ff;
      self_in   = self_ff;
      vis_in    = vis_ff;
      wr_en     = 1'b0;
      wr_addr   = row_addr(xi, yi);
      wr_data   = solid_ff ? (rd_data | z_onehot) : (rd_data & ~z_onehot);
      rd_addr   = row_addr(int'(req_bus.pos_x), int'(req_bus.pos_y));

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         ST_IDLE: begin
            if (req_fire) begin
               x_in      = req_bus.pos_x;
               y_in      = req_bus.pos_y;
               z_in      = req_bus.pos_z;
               solid_in  = req_bus.solid;
               inside_in = (int'(req_bus.pos_x) < CHUNK_SIDE) &&
                           (int'(req_bus.pos_y) < CHUNK_TALL) &&
                           (int'(req_bus.pos_z) < CHUNK_SIDE);
            end
         end
         ST_WRITE: begin
            wr_en = inside_ff;
         end
         ST_READ: begin
            case (step_ff)
               STEP_SELF: begin
                  rd_addr = row_addr(xi - 1, yi);
                  self_in = inside_ff && bit_z;
                  vis_in[FACE_FRONT] = !((zi + 1 < CHUNK_SIDE) && row_bit(rd_data, zi + 1));
                  vis_in[FACE_BACK]  = !((zi != 0) && row_bit(rd_data, zi - 1));
               end
               STEP_LEFT: begin
                  rd_addr = row_addr(xi + 1, yi);
                  vis_in[FACE_LEFT] = !((xi != 0) && bit_z);
               end
               STEP_RIGHT: begin
                  rd_addr = row_addr(xi, yi - 1);
                  vis_in[FACE_RIGHT] = !((xi + 1 < CHUNK_SIDE) && bit_z);
               end
               STEP_BOTTOM: begin
                  rd_addr = row_addr(xi, yi + 1);
                  vis_in[FACE_BOTTOM] = !((yi != 0) && bit_z);
               end
               STEP_TOP: begin
                  vis_in[FACE_TOP] = !((yi + 1 < CHUNK_TALL) && bit_z);
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      mask_in      = mask_ff;
      vsolid_in    = vsolid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         mask_in      = self_ff ? vis_ff : '0;
         vsolid_in    = self_ff;
      end

      rsp_bus.valid       = rsp_valid_ff;
      rsp_bus.face_mask   = mask_ff;
      rsp_bus.voxel_solid = vsolid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= STEP_SELF;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      solid_ff  <= solid_in;
      inside_ff <= inside_in;
      self_ff   <= self_in;
      vis_ff    <= vis_in;
      mask_ff   <= mask_in;
      vsolid_ff <= vsolid_in;
   end

   // a write beat never produces a response
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_bus.kind == KIND_WRITE) |=> !$rose(rsp_bus.valid))
      else $error("response raised after write beat");

   // empty voxel gives an empty mask
   a_empty_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.voxel_solid |-> rsp_bus.face_mask == '0)
      else $error("nonzero mask for empty voxel");

   // clearing pass writes zero rows and blocks requests
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> wr_en && wr_data == '0 && !req_bus.ready)
      else $error("clearing pass misbehaved");

endmodule
`default_nettype wire
